>>> rtl/core/open_addressing_hash_table_assert.svh
// Assertion macros for the open addressing hash table.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("oaht assertion failed");
`define OAHT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("oaht assertion failed");
`else
`define OAHT_ASSERT(label, clk, rstn, prop)
`define OAHT_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> rtl/core/oaht_pkg.sv
// Shared types and constants of the open addressing hash table.
// No dependencies.
`default_nettype none
package oaht_pkg;
    localparam int SLOTS_DEF      = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HOME,
        S_WALK,
        S_FINISH
    } oaht_state_t;

    typedef struct packed {
        logic valid;
        logic found;
        logic free_hi;
        logic free_lo;
    } oaht_tok_t;

    typedef struct packed {
        logic wr_set;
        logic wr_clr;
    } oaht_cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/open_addressing_hash_table.sv
// Open addressing hash table with linear probing, built as a chain of slot cells.
// Depends on oaht_pkg, oaht_home, oaht_cell and open_addressing_hash_table_assert.svh.
//
// Requests arrive on the s_ channel (kind, key, data_in) and each gives one
// item on the m_ channel (status, data_out, occupancy), in order.
// An accepted item first gets its home slot: the low key bits when SLOTS is a
// power of two, otherwise eight key bits per step (KEY_BITS/8 rounded up
// steps, here called ND) in the remainder unit. A search
// token then runs through the SLOTS cells, one cell per cycle, collecting the
// slot that holds the key and the first free slots at and after the home
// slot and anywhere. The last cycle writes the chosen slot and loads the
// output register.
// One item is in work at a time: a new request is taken only once the
// previous one has left the finish step.
// The output register holds a finished item while the next one is searched;
// only the final write-back step waits when the receiver stalls.
// Reset empties the table and clears the entry count at once.
`default_nettype none
`include "open_addressing_hash_table_assert.svh"
module open_addressing_hash_table #(
    parameter int SLOTS      = oaht_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [31:0] s_key,
    input  wire logic [31:0] s_data_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_data_out,
    output logic [6:0]       m_occupancy
);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    oaht_pkg::oaht_state_t state_reg, state_next;

    logic [1:0]            kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IDX_W-1:0]      home_reg;
    logic                  launch_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  fnd_reg, hi_reg, lo_reg;
    logic [IDX_W-1:0]      fidx_reg, hidx_reg, lidx_reg;
    logic [VALUE_BITS-1:0] fval_reg;

    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [31:0]           m_data_out_reg;
    logic [6:0]            m_occupancy_reg;

    logic                  accept;
    logic                  home_start;
    logic                  home_done;
    logic [IDX_W-1:0]      home;
    logic                  load;
    logic [63:0]           key_wide;
    logic [63:0]           val_wide;

    logic [1:0]            status_c;
    logic [VALUE_BITS-1:0] dout_c;
    oaht_pkg::oaht_cmd_t   cmd_c, cmd;
    logic [IDX_W-1:0]      cmd_idx;
    logic [VALUE_BITS+31:0] dout_wide;
    logic [CNT_W+6:0]      occ_wide;

    oaht_pkg::oaht_tok_t   tok_head;
    oaht_pkg::oaht_tok_t   tok  [SLOTS+1];
    logic [IDX_W-1:0]      fidx [SLOTS+1];
    logic [VALUE_BITS-1:0] fval [SLOTS+1];
    logic [IDX_W-1:0]      hidx [SLOTS+1];
    logic [IDX_W-1:0]      lidx [SLOTS+1];

    assign accept   = s_valid && s_ready;
    assign key_wide = {32'b0, s_key};
    assign val_wide = {32'b0, s_data_in};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            oaht_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = oaht_pkg::S_HOME;
                end
            end
            oaht_pkg::S_HOME: begin
                if (home_done) begin
                    state_next = oaht_pkg::S_WALK;
                end
            end
            oaht_pkg::S_WALK: begin
                if (tok[SLOTS].valid) begin
                    state_next = oaht_pkg::S_FINISH;
                end
            end
            oaht_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = oaht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        home_start = 1'b0;
        load       = 1'b0;
        case (state_reg)
            oaht_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                home_start = s_valid;
            end
            oaht_pkg::S_FINISH: begin
                load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= oaht_pkg::S_IDLE;
            launch_reg  <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= (state_reg == oaht_pkg::S_HOME) && home_done;
            if (load) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            key_reg  <= key_wide[KEY_BITS-1:0];
            val_reg  <= val_wide[VALUE_BITS-1:0];
        end
        if (state_reg == oaht_pkg::S_HOME && home_done) begin
            home_reg <= home;
        end
        if (state_reg == oaht_pkg::S_WALK && tok[SLOTS].valid) begin
            fnd_reg  <= tok[SLOTS].found;
            hi_reg   <= tok[SLOTS].free_hi;
            lo_reg   <= tok[SLOTS].free_lo;
            fidx_reg <= fidx[SLOTS];
            fval_reg <= fval[SLOTS];
            hidx_reg <= hidx[SLOTS];
            lidx_reg <= lidx[SLOTS];
        end
        if (load) begin
            m_status_reg    <= status_c;
            m_data_out_reg  <= dout_wide[31:0];
            m_occupancy_reg <= occ_wide[6:0];
        end
    end

    always_comb begin
        status_c = oaht_pkg::ST_DONE;
        dout_c   = '0;
        cmd_c    = '0;
        cmd_idx  = fidx_reg;
        cnt_next = cnt_reg;
        case (kind_reg)
            oaht_pkg::KIND_LOOKUP: begin
                if (fnd_reg) begin
                    dout_c = fval_reg;
                end else begin
                    status_c = oaht_pkg::ST_ABSENT;
                end
            end
            oaht_pkg::KIND_INSERT: begin
                if (fnd_reg) begin
                    status_c = oaht_pkg::ST_PRESENT;
                end else if (hi_reg) begin
                    cmd_c.wr_set = 1'b1;
                    cmd_idx      = hidx_reg;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end else if (lo_reg) begin
                    cmd_c.wr_set = 1'b1;
                    cmd_idx      = lidx_reg;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end else begin
                    status_c = oaht_pkg::ST_FULL;
                end
            end
            oaht_pkg::KIND_REMOVE: begin
                if (fnd_reg) begin
                    cmd_c.wr_clr = 1'b1;
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end else begin
                    status_c = oaht_pkg::ST_ABSENT;
                end
            end
            default: begin
                status_c = oaht_pkg::ST_DONE;
            end
        endcase
    end

    assign cmd       = load ? cmd_c : '0;
    assign dout_wide = {32'b0, dout_c};
    assign occ_wide  = {7'b0, cnt_next};

    oaht_home #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_home (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (home_start),
        .key     (key_wide[KEY_BITS-1:0]),
        .done    (home_done),
        .home    (home)
    );

    always_comb begin
        tok_head       = '0;
        tok_head.valid = launch_reg;
    end

    assign tok[0]  = tok_head;
    assign fidx[0] = '0;
    assign fval[0] = '0;
    assign hidx[0] = '0;
    assign lidx[0] = '0;

    generate
        for (genvar i = 0; i < SLOTS; i++) begin : g_cell
            oaht_cell #(
                .IDX        (i),
                .IDX_W      (IDX_W),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .req_key   (key_reg),
                .req_home  (home_reg),
                .tok_in    (tok[i]),
                .fidx_in   (fidx[i]),
                .fval_in   (fval[i]),
                .hidx_in   (hidx[i]),
                .lidx_in   (lidx[i]),
                .tok_out   (tok[i+1]),
                .fidx_out  (fidx[i+1]),
                .fval_out  (fval[i+1]),
                .hidx_out  (hidx[i+1]),
                .lidx_out  (lidx[i+1]),
                .cmd       (cmd),
                .cmd_idx   (cmd_idx),
                .cmd_key   (key_reg),
                .cmd_value (val_reg)
            );
        end
    endgenerate

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_data_out  = m_data_out_reg;
    assign m_occupancy = m_occupancy_reg;

    `OAHT_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(SLOTS))
    `OAHT_ASSERT(a_end_in_walk, aclk, aresetn, tok[SLOTS].valid |-> state_reg == oaht_pkg::S_WALK)
    `OAHT_ASSERT(a_full_count, aclk, aresetn, (load && status_c == oaht_pkg::ST_FULL) |-> cnt_reg == CNT_W'(SLOTS))
    `OAHT_ASSERT(a_insert_new, aclk, aresetn, cmd.wr_set |-> !fnd_reg)
endmodule
`default_nettype wire

>>> rtl/core/oaht_home.sv
// Home slot unit: key modulo the slot count, eight key bits per cycle by reciprocal multiplication.
// A power-of-two slot count takes the low key bits. Depends on oaht_pkg.
`default_nettype none
module oaht_home #(
    parameter int SLOTS    = oaht_pkg::SLOTS_DEF,
    parameter int KEY_BITS = oaht_pkg::KEY_BITS_DEF,
    parameter int IDX_W    = $clog2(SLOTS)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [KEY_BITS-1:0] key,
    output logic                     done,
    output logic [IDX_W-1:0]         home
);
    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (POW2) begin : g_pow2
            logic                    done_reg;
            logic [IDX_W-1:0]        home_reg;
            logic [IDX_W+KEY_BITS-1:0] key_wide;

            assign key_wide = {{IDX_W{1'b0}}, key};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    home_reg <= key_wide[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_serial
            localparam int DW = 8;
            localparam int ND = (KEY_BITS + DW - 1) / DW;
            localparam int PW = ND * DW;
            localparam int TW = IDX_W + DW;
            localparam int CW = $clog2(ND + 1);
            localparam logic [DW:0] RECIP = (DW + 1)'((2 ** TW) / SLOTS);
            logic                busy_reg;
            logic                done_reg;
            logic [CW-1:0]       cnt_reg;
            logic [PW-1:0]       dig_reg;
            logic [IDX_W-1:0]    rem_reg;
            logic [TW-1:0]       trial;
            logic [TW+DW:0]      prod;
            logic [DW-1:0]       q_est;
            logic [TW-1:0]       diff;
            logic [TW-1:0]       red;

            // The quotient estimate is at most one too small, so one
            // conditional subtraction finishes the remainder.
            assign trial = {rem_reg, dig_reg[PW-1 -: DW]};
            assign prod  = (TW + DW + 1)'(trial) * (TW + DW + 1)'(RECIP);
            assign q_est = prod[TW+DW-1:TW];
            assign diff  = trial - TW'(q_est) * TW'(SLOTS);
            assign red   = (diff >= TW'(SLOTS)) ? diff - TW'(SLOTS) : diff;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= 1'b0;
                    if (start) begin
                        busy_reg <= 1'b1;
                    end else if (busy_reg && cnt_reg == CW'(ND - 1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    dig_reg <= PW'(key);
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end else if (busy_reg) begin
                    dig_reg <= dig_reg << DW;
                    rem_reg <= red[IDX_W-1:0];
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate
endmodule
`default_nettype wire

>>> rtl/core/oaht_cell.sv
// One slot of the table plus one stage of the search token chain.
// Depends on oaht_pkg for the token and write command types.
`default_nettype none
module oaht_cell #(
    parameter int IDX        = 0,
    parameter int IDX_W      = 6,
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [KEY_BITS-1:0]   req_key,
    input  wire logic [IDX_W-1:0]      req_home,
    input  wire oaht_pkg::oaht_tok_t   tok_in,
    input  wire logic [IDX_W-1:0]      fidx_in,
    input  wire logic [VALUE_BITS-1:0] fval_in,
    input  wire logic [IDX_W-1:0]      hidx_in,
    input  wire logic [IDX_W-1:0]      lidx_in,
    output oaht_pkg::oaht_tok_t        tok_out,
    output logic [IDX_W-1:0]           fidx_out,
    output logic [VALUE_BITS-1:0]      fval_out,
    output logic [IDX_W-1:0]           hidx_out,
    output logic [IDX_W-1:0]           lidx_out,
    input  wire oaht_pkg::oaht_cmd_t   cmd,
    input  wire logic [IDX_W-1:0]      cmd_idx,
    input  wire logic [KEY_BITS-1:0]   cmd_key,
    input  wire logic [VALUE_BITS-1:0] cmd_value
);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                  used_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    oaht_pkg::oaht_tok_t   tok_reg, tok_next;
    logic [IDX_W-1:0]      fidx_reg, fidx_next;
    logic [VALUE_BITS-1:0] fval_reg, fval_next;
    logic [IDX_W-1:0]      hidx_reg, hidx_next;
    logic [IDX_W-1:0]      lidx_reg, lidx_next;
    logic                  mine;
    logic                  match;
    logic                  take_hi;
    logic                  take_lo;

    assign mine    = (cmd_idx == MY_IDX);
    assign match   = used_reg && (key_reg == req_key);
    assign take_hi = !tok_in.free_hi && !used_reg && (MY_IDX >= req_home);
    assign take_lo = !tok_in.free_lo && !used_reg;

    always_comb begin
        tok_next.valid   = tok_in.valid;
        tok_next.found   = tok_in.found | match;
        tok_next.free_hi = tok_in.free_hi | take_hi;
        tok_next.free_lo = tok_in.free_lo | take_lo;
        fidx_next        = match ? MY_IDX : fidx_in;
        fval_next        = match ? value_reg : fval_in;
        hidx_next        = take_hi ? MY_IDX : hidx_in;
        lidx_next        = take_lo ? MY_IDX : lidx_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            tok_reg <= tok_next;
            if (cmd.wr_set && mine) begin
                used_reg <= 1'b1;
            end else if (cmd.wr_clr && mine) begin
                used_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fidx_reg <= fidx_next;
        fval_reg <= fval_next;
        hidx_reg <= hidx_next;
        lidx_reg <= lidx_next;
        if (cmd.wr_set && mine) begin
            key_reg   <= cmd_key;
            value_reg <= cmd_value;
        end
    end

    assign tok_out  = tok_reg;
    assign fidx_out = fidx_reg;
    assign fval_out = fval_reg;
    assign hidx_out = hidx_reg;
    assign lidx_out = lidx_reg;
endmodule
`default_nettype wire
